/* hw/rtl/ncq_pkg.sv */
// Shared types, constants and helpers for the N-of-M flaw qualifier.
// No dependencies; every other file of the block but ncq_ram imports this package.
package ncq_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int WIN_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SLOTS      = 2 ** WIN_W;
  localparam int NUM_CHAN   = 2;
  localparam int ADDR_W     = WIN_W + 1;
  localparam int RAM_DEPTH  = NUM_CHAN * SLOTS;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

  localparam int AMP_W      = 8;
  localparam int NEED_W     = 5;
  localparam int WIN_REG_W  = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef logic [WIN_W-1:0]  slot_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [AMP_W-1:0]  amp_t;

  // operation codes
  localparam logic [1:0] OP_SAMPLE     = 2'd0;
  localparam logic [1:0] OP_CLEAR      = 2'd1;
  localparam logic [1:0] OP_RESET_PEAK = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEED_INNER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_INNER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_INNER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEED_OUTER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_OUTER    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_OUTER = 3'd5;

  localparam logic [NEED_W-1:0]    NEED_RESET   = 5'd1;
  localparam amp_t                 THR_RESET    = 8'd20;
  localparam logic [WIN_REG_W-1:0] WINDOW_RESET = 5'd1;
  localparam amp_t                 THR_MIN      = 8'd3;
  localparam amp_t                 THR_FLOOR    = 8'd2;
  localparam int                   NEAR_MARGIN  = 2;

  // x*4/5 as (4x * 205) >> 10, exact for 4x below 1024
  localparam int FIFTH_MUL   = 205;
  localparam int FIFTH_SHIFT = 10;
  localparam int PROD_W      = AMP_W + 2 + 8;

  typedef struct packed {
    logic [NEED_W-1:0]    need_count;
    amp_t                 threshold;
    logic [WIN_REG_W-1:0] window;
  } chan_cfg_t;

  // last valid slot index of the effective window
  function automatic slot_t last_slot(input logic [WIN_REG_W-1:0] window);
    int w;
    w = int'(window);
    if (w == 0) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    return slot_t'(w - 1);
  endfunction

  function automatic amp_t four_fifths(input amp_t thr);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'({thr, 2'b00}) * PROD_W'(FIFTH_MUL);
    return prod[FIFTH_SHIFT +: AMP_W];
  endfunction

endpackage

/* hw/rtl/ncq_if.sv */
// Valid/ready channel interfaces for the qualifier's input and result streams.
// Depends on ncq_pkg for field widths.
interface ncq_in_if import ncq_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       channel_select;
  amp_t       amplitude;

  modport source (output valid, operation, channel_select, amplitude, input ready);
  modport sink   (input valid, operation, channel_select, amplitude, output ready);
endinterface

interface ncq_out_if import ncq_pkg::*; ();
  logic valid;
  logic ready;
  amp_t peak_hold;
  amp_t window_reading;
  logic qualified;

  modport source (output valid, peak_hold, window_reading, qualified, input ready);
  modport sink   (input valid, peak_hold, window_reading, qualified, output ready);
endinterface

/* hw/rtl/ncq_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ncq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/ncq_cfg.sv */
// Configuration register file: need count, threshold and window per channel.
// Depends on ncq_pkg.
module ncq_cfg import ncq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output chan_cfg_t [NUM_CHAN-1:0] chan_cfg
);

  amp_t thr_clamped;
  assign thr_clamped = (cfg_data < THR_MIN) ? THR_FLOOR : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        chan_cfg[c].need_count <= NEED_RESET;
        chan_cfg[c].threshold  <= THR_RESET;
        chan_cfg[c].window     <= WINDOW_RESET;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NEED_INNER:   chan_cfg[0].need_count <= cfg_data[NEED_W-1:0];
        REG_THR_INNER:    chan_cfg[0].threshold  <= thr_clamped;
        REG_WINDOW_INNER: chan_cfg[0].window     <= cfg_data[WIN_REG_W-1:0];
        REG_NEED_OUTER:   chan_cfg[1].need_count <= cfg_data[NEED_W-1:0];
        REG_THR_OUTER:    chan_cfg[1].threshold  <= thr_clamped;
        REG_WINDOW_OUTER: chan_cfg[1].window     <= cfg_data[WIN_REG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/ncq_core.sv */
// Window store and scan sequencer: writes each sample of an enabled channel into the cell RAM, then
// reads the channel's window back one cell a cycle to count hits and find the max.
// Depends on ncq_pkg, ncq_if and ncq_ram.
module ncq_core import ncq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  chan_cfg_t [NUM_CHAN-1:0] chan_cfg,
  ncq_in_if.sink                   item,
  ncq_out_if.source                result
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_RESULT} state_t;

  state_t     state;
  logic [1:0] op_q;
  logic       ch_q;
  logic       active_q;
  slot_t      idx;
  slot_t      last_idx;
  logic       rd_pend;
  logic       rd_vbit;
  count_t     count;
  amp_t       maxv;
  slot_t      write_slot [NUM_CHAN];
  amp_t       held_peak [NUM_CHAN];
  logic [SLOTS-1:0] cell_valid [NUM_CHAN];

  logic res_valid;
  amp_t res_peak;
  amp_t res_reading;
  logic res_qual;

  // accept-side decode
  logic      accept;
  logic      ch_in;
  chan_cfg_t cfg_in;
  slot_t     last_in;
  slot_t     slot_in;
  slot_t     slot_after;
  logic      sample_in;

  assign accept    = item.valid && item.ready;
  assign ch_in     = item.channel_select;
  assign cfg_in    = chan_cfg[ch_in];
  assign last_in   = last_slot(cfg_in.window);
  // a stale slot beyond a shrunken window restarts at slot 0
  assign slot_in    = (write_slot[ch_in] > last_in) ? '0 : write_slot[ch_in];
  assign slot_after = (slot_in == last_in) ? '0 : slot_in + slot_t'(1);
  assign sample_in  = (item.operation == OP_SAMPLE) && (cfg_in.need_count != '0);

  // cell RAM
  addr_t ram_raddr;
  amp_t  ram_rdata;

  assign ram_raddr = {ch_q, idx};

  ncq_ram #(
    .WIDTH(AMP_W),
    .DEPTH(RAM_DEPTH)
  ) u_cells (
    .clk  (clk),
    .we   (accept && sample_in),
    .waddr({ch_in, slot_in}),
    .wdata(item.amplitude),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // accumulation on returning read data; never-written cells read as zero
  amp_t cell_amp;
  logic hit;
  assign cell_amp = rd_vbit ? ram_rdata : '0;
  assign hit      = cell_amp >= chan_cfg[ch_q].threshold;

  // result evaluation
  amp_t thr_q;
  logic qual;
  logic near;
  amp_t reading;
  amp_t new_peak;

  assign thr_q    = chan_cfg[ch_q].threshold;
  assign qual     = int'(count) >= int'(chan_cfg[ch_q].need_count);
  assign near     = ({1'b0, maxv} + 9'(NEAR_MARGIN)) >= {1'b0, thr_q};
  assign reading  = qual ? maxv : (near ? four_fifths(thr_q) : maxv);
  assign new_peak = (reading > held_peak[ch_q]) ? reading : held_peak[ch_q];

  assign item.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_pend   <= 1'b0;
      res_valid <= 1'b0;
      for (int c = 0; c < NUM_CHAN; c++) begin
        write_slot[c] <= '0;
        held_peak[c]  <= '0;
        cell_valid[c] <= '0;
      end
    end else begin
      rd_pend <= (state == S_SCAN);
      rd_vbit <= cell_valid[ch_q][idx];

      if (rd_pend) begin
        if (hit) count <= count + count_t'(1);
        if (cell_amp > maxv) maxv <= cell_amp;
      end

      // a result loaded at this edge is handled in S_RESULT
      if (res_valid && result.ready && state != S_RESULT) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q     <= item.operation;
            ch_q     <= ch_in;
            active_q <= sample_in;
            idx      <= '0;
            last_idx <= last_in;
            count    <= '0;
            maxv     <= '0;
            if (item.operation == OP_CLEAR) begin
              cell_valid[ch_in] <= '0;
            end
            if (item.operation == OP_RESET_PEAK) begin
              held_peak[ch_in] <= '0;
            end
            if (sample_in) begin
              cell_valid[ch_in][slot_in] <= 1'b1;
              write_slot[ch_in]          <= slot_after;
              state                      <= S_SCAN;
            end else begin
              state <= S_RESULT;
            end
          end
        end
        S_SCAN: begin
          idx <= idx + slot_t'(1);
          if (idx == last_idx) state <= S_DRAIN;
        end
        S_DRAIN: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
            if (active_q) begin
              held_peak[ch_q] <= new_peak;
              res_peak        <= new_peak;
              res_reading     <= reading;
              res_qual        <= qual;
            end else begin
              // disabled sample reports all zero; other operations the held peak
              res_peak    <= (op_q == OP_SAMPLE) ? '0 : held_peak[ch_q];
              res_reading <= '0;
              res_qual    <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid          = res_valid;
  assign result.peak_hold      = res_peak;
  assign result.window_reading = res_reading;
  assign result.qualified      = res_qual;

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> idx <= last_idx)
    else $error("scan index ran past the window");

  a_read_follows_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(state == S_SCAN))
    else $error("read data flagged without a scan read");

  a_peak_covers_reading: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_peak >= res_reading)
    else $error("held peak below the reported reading");

  a_qualified_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_qual |-> res_reading >= THR_FLOOR)
    else $error("qualified reading below any legal threshold");

endmodule

/* hw/rtl/nc_of_m_flaw_qualifier_unit.sv */
// N-of-M flaw qualifier, top level: two gate channels (inner, outer), each with a
// window of up to 16 recent amplitudes held in one shared cell RAM. A sample
// transaction writes its cell, then the window of w cells, w being the effective
// window (1 to 16), is read back one cell per cycle through the RAM's single read
// port before the result is loaded; clear, reset-peak and disabled-channel
// transactions go straight to the result. One transaction is in flight at a time;
// the result register lets the next transaction be accepted while a result still
// waits. Clearing after reset or on a clear transaction is immediate: cells never
// written since read as zero. Configuration writes are taken every cycle.
// Depends on ncq_pkg, ncq_if, ncq_cfg and ncq_core.
module nc_of_m_flaw_qualifier_unit import ncq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ncq_in_if.sink                item,
  ncq_out_if.source             result
);

  chan_cfg_t [NUM_CHAN-1:0] chan_cfg;

  ncq_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .chan_cfg (chan_cfg)
  );

  ncq_core u_core (
    .clk     (clk),
    .rst     (rst),
    .chan_cfg(chan_cfg),
    .item    (item),
    .result  (result)
  );

endmodule
